// File: rtl/ufcq_pkg.sv
package ufcq_pkg;

  localparam int UFCQ_MAX_NODES   = 1024;
  localparam int UFCQ_WEIGHT_BITS = 16;

  localparam int NODE_W      = 10;
  localparam int NUM_NODES_W = 11;

  localparam logic [NUM_NODES_W-1:0] NUM_NODES_RST = 11'd1024;

  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_A,
    CUR_B,
    CUR_PARENT
  } cur_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_COMP,
    WR_SMALL,
    WR_BIG,
    WR_SAME
  } wr_sel_e;

  typedef struct packed {
    logic     item_load;
    logic     rd_en;
    cur_sel_e cur_sel;
    wr_sel_e  wr_sel;
    logic     save_ra;
    logic     save_rb;
    logic     side_b;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic item_bad;
    logic item_query;
    logic rd_root;
    logic comp_go;
    logic roots_equal;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/ufcq_ram.sv
module ufcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ufcq_ctrl.sv
module ufcq_ctrl import ufcq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FA_RD,
    S_FA_EV,
    S_CA_RD,
    S_CA_EV,
    S_FB_RD,
    S_FB_EV,
    S_CB_RD,
    S_CB_EV,
    S_APPLY,
    S_MERGE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.cur_sel     = CUR_HOLD;
    cmd_o.wr_sel      = WR_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_sel = WR_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.item_bad) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.cur_sel = CUR_A;
          state_d       = S_FA_RD;
        end
      end
      S_FA_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_FA_EV;
      end
      S_FA_EV: begin
        if (sts_i.rd_root) begin
          cmd_o.save_ra = 1'b1;
          cmd_o.cur_sel = CUR_A;
          state_d       = S_CA_RD;
        end else begin
          cmd_o.cur_sel = CUR_PARENT;
          state_d       = S_FA_RD;
        end
      end
      S_CA_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CA_EV;
      end
      S_CA_EV: begin
        if (sts_i.comp_go) begin
          cmd_o.wr_sel  = WR_COMP;
          cmd_o.cur_sel = CUR_PARENT;
          state_d       = S_CA_RD;
        end else begin
          cmd_o.cur_sel = CUR_B;
          state_d       = S_FB_RD;
        end
      end
      S_FB_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_FB_EV;
      end
      S_FB_EV: begin
        if (sts_i.rd_root) begin
          cmd_o.save_rb = 1'b1;
          cmd_o.cur_sel = CUR_B;
          state_d       = S_CB_RD;
        end else begin
          cmd_o.cur_sel = CUR_PARENT;
          state_d       = S_FB_RD;
        end
      end
      S_CB_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.side_b = 1'b1;
        state_d      = S_CB_EV;
      end
      S_CB_EV: begin
        cmd_o.side_b = 1'b1;
        if (sts_i.comp_go) begin
          cmd_o.wr_sel  = WR_COMP;
          cmd_o.cur_sel = CUR_PARENT;
          state_d       = S_CB_RD;
        end else begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (sts_i.item_query) begin
          state_d = S_EMIT;
        end else if (sts_i.roots_equal) begin
          cmd_o.wr_sel = WR_SAME;
          state_d      = S_IDLE;
        end else begin
          cmd_o.wr_sel = WR_SMALL;
          state_d      = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd_o.wr_sel = WR_BIG;
        state_d      = S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: rtl/ufcq_dp.sv
module ufcq_dp import ufcq_pkg::*; #(
  parameter int MAX_NODES   = UFCQ_MAX_NODES,
  parameter int WEIGHT_BITS = UFCQ_WEIGHT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [NUM_NODES_W-1:0] cfg_wdata_i,
  input  logic                   req_type_i,
  input  logic [NODE_W-1:0]      node_a_i,
  input  logic [NODE_W-1:0]      node_b_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [WEIGHT_BITS:0]   cost_o,
  output logic                   bad_node_o,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int PW = $clog2(MAX_NODES + 1) + 1;
  localparam int CW = WEIGHT_BITS + 1;
  localparam int EW = PW + CW;
  localparam logic [16:0]   MaxNodesW = 17'(MAX_NODES);
  localparam logic [AW-1:0] LastAddr  = AW'(MAX_NODES - 1);

  logic [NUM_NODES_W-1:0] num_nodes_q;
  logic [AW-1:0]          clr_q;
  logic                   out_valid_q;

  logic                   type_q;
  logic [NODE_W-1:0]      a_q, b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic                   bad_q;
  logic [AW-1:0]          cur_q, cur_d;
  logic [AW-1:0]          ra_q, rb_q;
  logic signed [PW-1:0]   ra_psz_q, rb_psz_q;
  logic [CW-1:0]          ra_and_q, rb_and_q;
  logic [CW-1:0]          cost_q;
  logic                   bad_node_q;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [EW-1:0]          ram_rdata;

  logic signed [PW-1:0]   rd_psz;
  logic [CW-1:0]          rd_and;
  logic [AW-1:0]          rd_parent;
  logic [AW-1:0]          root_sel;
  logic                   bad_in;
  logic                   ra_big;
  logic [AW-1:0]          big_addr, small_addr;
  logic signed [PW-1:0]   big_psz, small_psz;
  logic [CW-1:0]          small_and;
  logic [CW-1:0]          w_ext;
  logic [CW-1:0]          merged;
  logic                   roots_equal;
  logic                   out_free;

  ufcq_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cur_q),
    .rdata_o (ram_rdata)
  );

  assign rd_psz    = ram_rdata[EW-1 -: PW];
  assign rd_and    = ram_rdata[CW-1:0];
  assign rd_parent = rd_psz[AW-1:0];
  assign root_sel  = cmd_i.side_b ? rb_q : ra_q;

  assign bad_in = ({1'b0, node_a_i} >= num_nodes_q) || ({1'b0, node_b_i} >= num_nodes_q) ||
                  (17'(node_a_i) >= MaxNodesW) || (17'(node_b_i) >= MaxNodesW);

  assign roots_equal = (ra_q == rb_q);
  assign ra_big      = (ra_psz_q < rb_psz_q);
  assign big_addr    = ra_big ? ra_q : rb_q;
  assign small_addr  = ra_big ? rb_q : ra_q;
  assign big_psz     = ra_big ? ra_psz_q : rb_psz_q;
  assign small_psz   = ra_big ? rb_psz_q : ra_psz_q;
  assign small_and   = ra_big ? rb_and_q : ra_and_q;
  assign w_ext       = {1'b0, w_q};
  assign merged      = ra_and_q & rb_and_q & w_ext;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '1;
    case (cmd_i.wr_sel)
      WR_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
      end
      WR_COMP: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = {{(PW-AW){1'b0}}, root_sel, rd_and};
      end
      WR_SMALL: begin
        ram_we    = 1'b1;
        ram_waddr = small_addr;
        ram_wdata = {{(PW-AW){1'b0}}, big_addr, small_and};
      end
      WR_BIG: begin
        ram_we    = 1'b1;
        ram_waddr = big_addr;
        ram_wdata = {PW'(big_psz + small_psz), merged};
      end
      WR_SAME: begin
        ram_we    = 1'b1;
        ram_waddr = ra_q;
        ram_wdata = {ra_psz_q, ra_and_q & w_ext};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    cur_d = cur_q;
    case (cmd_i.cur_sel)
      CUR_A:      cur_d = AW'(a_q);
      CUR_B:      cur_d = AW'(b_q);
      CUR_PARENT: cur_d = rd_parent;
      default:    cur_d = cur_q;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= NUM_NODES_RST;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_nodes_q <= cfg_wdata_i;
      end
      if (cmd_i.wr_sel == WR_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      type_q <= req_type_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      w_q    <= weight_i;
      bad_q  <= bad_in;
    end
    cur_q <= cur_d;
    if (cmd_i.save_ra) begin
      ra_q     <= cur_q;
      ra_psz_q <= rd_psz;
      ra_and_q <= rd_and;
    end
    if (cmd_i.save_rb) begin
      rb_q     <= cur_q;
      rb_psz_q <= rd_psz;
      rb_and_q <= rd_and;
    end
    if (cmd_i.out_load) begin
      bad_node_q <= bad_q;
      cost_q     <= (!bad_q && roots_equal) ? ra_and_q : '1;
    end
  end

  assign sts_o.clr_last    = (clr_q == LastAddr);
  assign sts_o.item_bad    = bad_q;
  assign sts_o.item_query  = (type_q == REQ_QUERY);
  assign sts_o.rd_root     = rd_psz[PW-1];
  assign sts_o.comp_go     = (cur_q != root_sel) && !rd_psz[PW-1];
  assign sts_o.roots_equal = roots_equal;
  assign sts_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign cost_o      = cost_q;
  assign bad_node_o  = bad_node_q;

endmodule

// File: rtl/union_find_and_cost_query.sv
// Disjoint-set table over up to MAX_NODES nodes, union by size with path compression, where
// every component carries the AND of its edge weights. An edge item (req_type 0) merges the
// two components or ANDs the weight into the shared one and gives no result; a query item
// (req_type 1) returns the component AND, or -1 when the nodes are not connected. Any index not
// below min(num_nodes, MAX_NODES) gives one result with cost -1 and bad_node 1 and leaves the
// table alone. One item is in work at a time. The whole table sits in one RAM with registered
// read: each item walks the parent chain of node a to its root, walks it again to point every
// node on it at that root, does the same for node b, and then updates or reports. A chain has
// at most log2 of the component size parent hops. A bad item goes straight to its result. A
// result waits while an earlier one is held by out_stall_i. After reset a clearing pass writes
// every RAM entry with in_stall_o high; num_nodes may be written at any time meanwhile.
module union_find_and_cost_query import ufcq_pkg::*; #(
  parameter int MAX_NODES   = UFCQ_MAX_NODES,
  parameter int WEIGHT_BITS = UFCQ_WEIGHT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [NUM_NODES_W-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [NODE_W-1:0]      node_a_i,
  input  logic [NODE_W-1:0]      node_b_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [WEIGHT_BITS:0] cost_o,
  output logic                   bad_node_o
);

  cmd_t cmd;
  sts_t sts;
  logic [WEIGHT_BITS:0] cost;

  ufcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ufcq_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .weight_i    (weight_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cost_o      (cost),
    .bad_node_o  (bad_node_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign cost_o = $signed(cost);

endmodule

// File: rtl/ufcq_checker.sv
module ufcq_checker #(
  parameter int WEIGHT_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [WEIGHT_BITS:0]   cost_o,
  input logic                   bad_node_o
);

  // one transaction in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in work");

  // a flagged index never carries an aggregate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_node_o |-> cost_o == '1)
    else $error("bad node result without cost of -1");

  // cost is either -1 or a weight aggregate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cost_o[WEIGHT_BITS] |-> cost_o == '1)
    else $error("negative cost other than -1");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cost_o) && $stable(bad_node_o))
    else $error("stalled result changed");

endmodule

bind union_find_and_cost_query ufcq_checker #(
  .WEIGHT_BITS (WEIGHT_BITS)
) u_ufcq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cost_o      (cost_o),
  .bad_node_o  (bad_node_o)
);
